[hw/rtl/aac_pkg.sv]
// ----------------------------------------------------------------------------
// aac_pkg
// Shared types and constants of the alarm annunciator: the register map,
// register reset values, the input item layout and the buzzer melody timing.
// ----------------------------------------------------------------------------
package aac_pkg;

  // Width of the reported flag field on the result channel.
  localparam int REPORT_WIDTH = 32;

  // Configuration port geometry.
  localparam int ADDR_WIDTH = 5;
  localparam int DATA_WIDTH = 32;
  localparam int REG_IDX_WIDTH = 3;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_WIDTH-1:0] REG_BATTERY_LOW   = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_PATIENT_LIMIT = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_LOOP_LIMIT    = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_SNOOZE_TIME   = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_WD_TIMEOUT    = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_WD_ON         = 3'd5;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ALARMS_OFF    = 3'd6;

  // Register reset values.
  localparam logic [6:0]  RST_BATTERY_LOW   = 7'd20;
  localparam logic [10:0] RST_PATIENT_LIMIT = 11'd500;
  localparam logic [10:0] RST_LOOP_LIMIT    = 11'd650;
  localparam logic [19:0] RST_SNOOZE_TIME   = 20'd120000;
  localparam logic [15:0] RST_WD_TIMEOUT    = 16'd6000;

  // LED blink half period and the last melody step.
  localparam logic [8:0] BLINK_PERIOD_MS = 9'd250;
  localparam logic [4:0] MELODY_LAST     = 5'd20;

  typedef struct packed {
    logic [6:0]  battery_low_percent;
    logic [10:0] patient_pressure_limit;
    logic [10:0] loop_pressure_limit;
    logic [19:0] snooze_time_ms;
    logic [15:0] watchdog_timeout_ms;
    logic        watchdog_on;
    logic        alarms_off;
  } cfg_t;

  // Side effects of a register write on the alarm state.
  typedef struct packed {
    logic wd_restart;
    logic alarms_clear;
  } cfg_evt_t;

  typedef struct packed {
    logic [31:0]        raise_mask;
    logic signed [11:0] patient_pressure;
    logic signed [11:0] loop_pressure;
    logic [6:0]         battery_percent;
    logic               on_battery;
    logic               snooze_request;
    logic               gui_alarm_clear;
    logic               clear_all;
    logic               watchdog_kick;
  } item_t;

  typedef struct packed {
    logic alarm_active;
    logic sound;
    logic led;
    logic relay;
    logic buzzer;
  } levels_t;

  // Time in milliseconds that each melody step lasts before moving on.
  function automatic logic [13:0] melody_wait(input logic [4:0] step);
    logic [13:0] w;
    case (step)
      5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11,
      5'd13, 5'd15, 5'd17, 5'd19:        w = 14'd150;
      5'd2, 5'd4, 5'd8, 5'd12, 5'd14, 5'd18: w = 14'd100;
      5'd6, 5'd16:                       w = 14'd300;
      5'd10:                             w = 14'd800;
      5'd20:                             w = 14'd10000;
      default:                           w = 14'd0;
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/aac_in_if.sv]
// ----------------------------------------------------------------------------
// aac_in_if
// Tick channel: one item per millisecond tick with events and sensor values.
// ----------------------------------------------------------------------------
interface aac_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        raise_mask;
  logic signed [11:0] patient_pressure;
  logic signed [11:0] loop_pressure;
  logic [6:0]         battery_percent;
  logic               on_battery;
  logic               snooze_request;
  logic               gui_alarm_clear;
  logic               clear_all;
  logic               watchdog_kick;

  modport source (
    output valid, raise_mask, patient_pressure, loop_pressure, battery_percent,
    output on_battery, snooze_request, gui_alarm_clear, clear_all, watchdog_kick,
    input  ready
  );

  modport sink (
    input  valid, raise_mask, patient_pressure, loop_pressure, battery_percent,
    input  on_battery, snooze_request, gui_alarm_clear, clear_all, watchdog_kick,
    output ready
  );
endinterface

[hw/rtl/aac_out_if.sv]
// ----------------------------------------------------------------------------
// aac_out_if
// Status channel: one item per tick with the reported flags and drive levels.
// ----------------------------------------------------------------------------
interface aac_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] reported_flags;
  logic        alarm_active;
  logic        sound_active;
  logic        led_drive;
  logic        relay_drive;
  logic        buzzer_drive;

  modport source (
    output valid, reported_flags, alarm_active, sound_active, led_drive,
    output relay_drive, buzzer_drive,
    input  ready
  );

  modport sink (
    input  valid, reported_flags, alarm_active, sound_active, led_drive,
    input  relay_drive, buzzer_drive,
    output ready
  );
endinterface

[hw/rtl/alarm_annunciator_with_melody.sv]
// ----------------------------------------------------------------------------
// alarm_annunciator_with_melody
// High-priority alarm annunciator with sticky flags, snooze and buzzer melody.
// ----------------------------------------------------------------------------
// Usage: send one item on the tick channel for every millisecond tick. Each
// item carries raised alarm bits, snooze, clear and watchdog-kick requests,
// the two pressures and the battery state. For every item the status channel
// returns exactly one item with the unsnoozed flags and the relay, LED and
// buzzer levels as they stand after that tick.
// An accepted item sits in the input register while the combinational alarm
// update works on it; the status register loads the result when the item
// leaves the input register. Throughput is one item per cycle while the
// receiver takes each status item; the core updates its state once per item.
// When the receiver stalls, the status register holds its item and the input
// register takes one more tick; the tick channel then drops ready until the
// status item is taken. Nothing is lost or repeated. Reset (synchronous, active
// high) clears all flags, timers and levels and loads the register defaults.
// Registers sit at byte address 4*index on the APB-style port; the user must
// write them only while no item is in flight. The block does not enforce this.
// ----------------------------------------------------------------------------
module alarm_annunciator_with_melody #(
  parameter int FLAG_WIDTH        = 32,
  parameter int BIT_BATTERY_LOW   = 0,
  parameter int BIT_PRESSURE_HIGH = 1,
  parameter int BIT_WATCHDOG      = 2,
  parameter int BIT_GUI_ALARM     = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  aac_in_if.sink                         tick,
  aac_out_if.source                      status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aac_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [aac_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [aac_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready
);
  import aac_pkg::*;

  cfg_t     cfg;
  cfg_evt_t evt;

  // Input register: holds one accepted tick until the core can process it.
  logic  in_valid;
  item_t in_item;
  logic  advance;

  // Status register.
  logic                  out_valid;
  logic [FLAG_WIDTH-1:0] out_flags;
  levels_t               out_levels;

  logic [FLAG_WIDTH-1:0] filtered_next;
  levels_t               levels_next;

  assign pready = 1'b1;

  aac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .evt     (evt)
  );

  // The core updates its state exactly once per item, in the cycle that the
  // item leaves the input register for the status register.
  assign advance    = in_valid && (!out_valid || status.ready);
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_item.raise_mask       <= tick.raise_mask;
      in_item.patient_pressure <= tick.patient_pressure;
      in_item.loop_pressure    <= tick.loop_pressure;
      in_item.battery_percent  <= tick.battery_percent;
      in_item.on_battery       <= tick.on_battery;
      in_item.snooze_request   <= tick.snooze_request;
      in_item.gui_alarm_clear  <= tick.gui_alarm_clear;
      in_item.clear_all        <= tick.clear_all;
      in_item.watchdog_kick    <= tick.watchdog_kick;
    end
  end

  aac_core #(
    .FLAG_WIDTH        (FLAG_WIDTH),
    .BIT_BATTERY_LOW   (BIT_BATTERY_LOW),
    .BIT_PRESSURE_HIGH (BIT_PRESSURE_HIGH),
    .BIT_WATCHDOG      (BIT_WATCHDOG),
    .BIT_GUI_ALARM     (BIT_GUI_ALARM)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .evt           (evt),
    .step          (advance),
    .item          (in_item),
    .filtered_next (filtered_next),
    .levels_next   (levels_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flags  <= filtered_next;
      out_levels <= levels_next;
    end
  end

  assign status.valid          = out_valid;
  assign status.reported_flags = REPORT_WIDTH'(out_flags);
  assign status.alarm_active   = out_levels.alarm_active;
  assign status.sound_active   = out_levels.sound;
  assign status.led_drive      = out_levels.led;
  assign status.relay_drive    = out_levels.relay;
  assign status.buzzer_drive   = out_levels.buzzer;

endmodule

[hw/rtl/aac_regs.sv]
// ----------------------------------------------------------------------------
// aac_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module aac_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [aac_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [aac_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [aac_pkg::DATA_WIDTH-1:0]   prdata,
  output aac_pkg::cfg_t                    cfg,
  output aac_pkg::cfg_evt_t                evt
);
  import aac_pkg::*;

  logic                     wr;
  logic [REG_IDX_WIDTH-1:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[ADDR_WIDTH-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_low_percent    <= RST_BATTERY_LOW;
      cfg.patient_pressure_limit <= RST_PATIENT_LIMIT;
      cfg.loop_pressure_limit    <= RST_LOOP_LIMIT;
      cfg.snooze_time_ms         <= RST_SNOOZE_TIME;
      cfg.watchdog_timeout_ms    <= RST_WD_TIMEOUT;
      cfg.watchdog_on            <= 1'b0;
      cfg.alarms_off             <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_BATTERY_LOW:   cfg.battery_low_percent    <= pwdata[6:0];
        REG_PATIENT_LIMIT: cfg.patient_pressure_limit <= pwdata[10:0];
        REG_LOOP_LIMIT:    cfg.loop_pressure_limit    <= pwdata[10:0];
        REG_SNOOZE_TIME:   cfg.snooze_time_ms         <= pwdata[19:0];
        REG_WD_TIMEOUT:    cfg.watchdog_timeout_ms    <= pwdata[15:0];
        REG_WD_ON:         cfg.watchdog_on            <= pwdata[0];
        REG_ALARMS_OFF:    cfg.alarms_off             <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Writing either enable register restarts the watchdog; switching alarms
  // off also wipes the alarm state.
  always_comb begin
    evt.wd_restart   = wr && (idx == REG_WD_ON || idx == REG_ALARMS_OFF);
    evt.alarms_clear = wr && (idx == REG_ALARMS_OFF) && pwdata[0];
  end

  always_comb begin
    unique case (idx)
      REG_BATTERY_LOW:   prdata = DATA_WIDTH'(cfg.battery_low_percent);
      REG_PATIENT_LIMIT: prdata = DATA_WIDTH'(cfg.patient_pressure_limit);
      REG_LOOP_LIMIT:    prdata = DATA_WIDTH'(cfg.loop_pressure_limit);
      REG_SNOOZE_TIME:   prdata = DATA_WIDTH'(cfg.snooze_time_ms);
      REG_WD_TIMEOUT:    prdata = DATA_WIDTH'(cfg.watchdog_timeout_ms);
      REG_WD_ON:         prdata = DATA_WIDTH'(cfg.watchdog_on);
      REG_ALARMS_OFF:    prdata = DATA_WIDTH'(cfg.alarms_off);
      default:           prdata = '0;
    endcase
  end

endmodule

[hw/rtl/aac_core.sv]
// ----------------------------------------------------------------------------
// aac_core
// Alarm state and the per-tick update: events, checks, snooze, melody, blink.
// ----------------------------------------------------------------------------
module aac_core #(
  parameter int FLAG_WIDTH        = 32,
  parameter int BIT_BATTERY_LOW   = 0,
  parameter int BIT_PRESSURE_HIGH = 1,
  parameter int BIT_WATCHDOG      = 2,
  parameter int BIT_GUI_ALARM     = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  aac_pkg::cfg_t          cfg,
  input  aac_pkg::cfg_evt_t      evt,
  input  logic                   step,
  input  aac_pkg::item_t         item,
  output logic [FLAG_WIDTH-1:0]  filtered_next,
  output aac_pkg::levels_t       levels_next
);
  import aac_pkg::*;

  // A bit position beyond the flag width shifts out and leaves no bit.
  localparam logic [FLAG_WIDTH-1:0] FlagOne     = FLAG_WIDTH'(1);
  localparam logic [FLAG_WIDTH-1:0] BatteryBit  = FlagOne << BIT_BATTERY_LOW;
  localparam logic [FLAG_WIDTH-1:0] PressureBit = FlagOne << BIT_PRESSURE_HIGH;
  localparam logic [FLAG_WIDTH-1:0] WatchdogBit = FlagOne << BIT_WATCHDOG;
  localparam logic [FLAG_WIDTH-1:0] GuiBit      = FlagOne << BIT_GUI_ALARM;

  logic [FLAG_WIDTH-1:0] alarm_flags, alarm_flags_next;
  logic [FLAG_WIDTH-1:0] snooze_mask, snooze_mask_next;
  logic [FLAG_WIDTH-1:0] filtered_flags;
  logic [19:0]           snooze_elapsed, snooze_elapsed_next;
  logic [15:0]           watchdog_elapsed, watchdog_elapsed_next;
  logic [8:0]            blink_elapsed, blink_elapsed_next;
  logic [13:0]           melody_elapsed, melody_elapsed_next;
  logic [4:0]            melody_step, melody_step_next;
  levels_t               levels;

  logic patient_high;
  logic loop_high;

  assign patient_high = item.patient_pressure > $signed({1'b0, cfg.patient_pressure_limit});
  assign loop_high    = item.loop_pressure > $signed({1'b0, cfg.loop_pressure_limit});

  always_comb begin
    alarm_flags_next      = alarm_flags;
    snooze_mask_next      = snooze_mask;
    filtered_next         = filtered_flags;
    snooze_elapsed_next   = snooze_elapsed;
    watchdog_elapsed_next = watchdog_elapsed;
    blink_elapsed_next    = blink_elapsed;
    melody_elapsed_next   = melody_elapsed;
    melody_step_next      = melody_step;
    levels_next           = levels;

    if (evt.wd_restart) begin
      watchdog_elapsed_next = '0;
    end

    if (evt.alarms_clear) begin
      alarm_flags_next    = '0;
      snooze_mask_next    = '0;
      filtered_next       = '0;
      blink_elapsed_next  = '0;
      melody_elapsed_next = '0;
      melody_step_next    = '0;
      levels_next         = '0;
    end else if (step) begin
      if (item.watchdog_kick) begin
        watchdog_elapsed_next = '0;
      end

      if (!cfg.alarms_off) begin
        // Events, in the order raise, GUI clear, clear all, snooze.
        alarm_flags_next = alarm_flags | item.raise_mask[FLAG_WIDTH-1:0];
        if (item.gui_alarm_clear) begin
          alarm_flags_next = alarm_flags_next & ~GuiBit;
        end
        if (item.clear_all) begin
          alarm_flags_next = '0;
          snooze_mask_next = '0;
        end
        if (item.snooze_request) begin
          snooze_mask_next    = alarm_flags_next;
          snooze_elapsed_next = '0;
          alarm_flags_next    = '0;
        end

        // Checks.
        if (item.on_battery && item.battery_percent < cfg.battery_low_percent) begin
          alarm_flags_next = alarm_flags_next | BatteryBit;
        end
        if (patient_high || loop_high) begin
          alarm_flags_next = alarm_flags_next | PressureBit;
        end
        if (cfg.watchdog_on && watchdog_elapsed_next > cfg.watchdog_timeout_ms) begin
          alarm_flags_next = alarm_flags_next | WatchdogBit;
        end

        filtered_next = alarm_flags_next & ~snooze_mask_next;
        if (snooze_elapsed_next > cfg.snooze_time_ms) begin
          snooze_mask_next = '0;
        end

        levels_next.alarm_active = |alarm_flags_next;
        levels_next.sound        = |filtered_next;

        // Melody sequencer.
        if (levels_next.sound) begin
          if (melody_step == '0) begin
            levels_next.buzzer  = 1'b1;
            melody_elapsed_next = '0;
            melody_step_next    = 5'd1;
          end else if (melody_step > MELODY_LAST) begin
            melody_step_next = '0;
          end else if (melody_elapsed > melody_wait(melody_step)) begin
            if (melody_step == MELODY_LAST) begin
              melody_step_next = '0;
            end else begin
              levels_next.buzzer  = ~melody_step[0];
              melody_elapsed_next = '0;
              melody_step_next    = melody_step + 5'd1;
            end
          end
        end else begin
          levels_next.buzzer = 1'b0;
          melody_step_next   = '0;
        end

        // LED blink and relay.
        if (levels_next.alarm_active) begin
          if (blink_elapsed > BLINK_PERIOD_MS) begin
            blink_elapsed_next = '0;
            levels_next.led    = ~levels.led;
          end
          levels_next.relay = 1'b1;
        end else begin
          levels_next.led   = 1'b0;
          levels_next.relay = 1'b0;
        end
      end

      // Millisecond counters advance once per tick and stick at full scale.
      if (snooze_elapsed_next != '1) begin
        snooze_elapsed_next = snooze_elapsed_next + 20'd1;
      end
      if (watchdog_elapsed_next != '1) begin
        watchdog_elapsed_next = watchdog_elapsed_next + 16'd1;
      end
      if (blink_elapsed_next != '1) begin
        blink_elapsed_next = blink_elapsed_next + 9'd1;
      end
      if (melody_elapsed_next != '1) begin
        melody_elapsed_next = melody_elapsed_next + 14'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_flags      <= '0;
      snooze_mask      <= '0;
      filtered_flags   <= '0;
      snooze_elapsed   <= '0;
      watchdog_elapsed <= '0;
      blink_elapsed    <= '0;
      melody_elapsed   <= '0;
      melody_step      <= '0;
      levels           <= '0;
    end else begin
      alarm_flags      <= alarm_flags_next;
      snooze_mask      <= snooze_mask_next;
      filtered_flags   <= filtered_next;
      snooze_elapsed   <= snooze_elapsed_next;
      watchdog_elapsed <= watchdog_elapsed_next;
      blink_elapsed    <= blink_elapsed_next;
      melody_elapsed   <= melody_elapsed_next;
      melody_step      <= melody_step_next;
      levels           <= levels_next;
    end
  end

endmodule
